### sv/dtsr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command codes and interface types of the span rasterizer.
package dtsr_pkg;

  // Store geometry and pixel format
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int COLOUR_BITS = 8;
  localparam int DEPTH_BITS  = 8;
  localparam int STORE_SIZE  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_SIZE);

  // Port field widths
  localparam int CMD_W     = 3;
  localparam int POS_W     = 10;
  localparam int EXT_W     = 9;
  localparam int FIELD_W   = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 17;

  // Internal arithmetic widths
  localparam int DIM_W   = CFG_W;
  localparam int COORD_W = POS_W + 2;            // start +/- extent never leaves this
  localparam int CNT_W   = EXT_W;                // pixel positions per span
  localparam int ACC_W   = DIM_W + COORD_W + 1;  // width * row + col, signed

  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(65536);
  localparam logic [CFG_W-1:0]   DIM_RESET = CFG_W'(256);

  typedef enum logic [CMD_W-1:0] {
    CMD_DOT     = 3'd0,
    CMD_DOT_Z   = 3'd1,
    CMD_HSPAN   = 3'd2,
    CMD_VSPAN   = 3'd3,
    CMD_OUTLINE = 3'd4,
    CMD_FILL    = 3'd5,
    CMD_READ    = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [COLOUR_BITS-1:0] colour_t;
  typedef logic [DEPTH_BITS-1:0]  depth_t;

  typedef struct packed {
    depth_t  depth;
    colour_t colour;
  } word_t;

  // One pixel request from the walker to the read-modify-write stage
  typedef struct packed {
    logic              valid;
    logic              rd;
    logic              tested;
    logic [ADDR_W-1:0] addr;
  } pix_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    word_t             wdata;
  } ram_port_t;

  typedef struct packed {
    logic busy;
    logic done;
  } walk_stat_t;

  typedef struct packed {
    colour_t            colour;
    depth_t             depth;
    logic [COUNT_W-1:0] count;
  } result_t;

endpackage

### sv/dtsr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module dtsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/dtsr_walker.sv
`timescale 1ns / 1ps
// Command sequencer: splits a command into spans, clips them in clip mode and walks pixel addresses.
module dtsr_walker
  import dtsr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmd_start,
  input  cmd_t                      cmd,
  input  logic                      clip,
  input  logic signed [POS_W-1:0]   pos_x,
  input  logic signed [POS_W-1:0]   pos_y,
  input  logic [EXT_W-1:0]          ext_w,
  input  logic [EXT_W-1:0]          ext_h,
  input  logic                      colour_nz,
  input  logic [FIELD_W-1:0]        skip,
  input  logic [DIM_W-1:0]          eff_w,
  input  logic [DIM_W-1:0]          eff_h,
  output walk_stat_t                stat,
  output pix_req_t                  req
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_ADDR  = 6'b000100,
    ST_RUN   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_DONE  = 6'b100000
  } wstate_t;

  localparam logic signed [COORD_W-1:0] ONE_C   = COORD_W'(1);
  localparam logic signed [COORD_W-1:0] TWO_C   = COORD_W'(2);
  localparam logic signed [ACC_W-1:0]   STORE_A = ACC_W'(STORE_SIZE);

  wstate_t state_r, state_nxt;

  // command registers
  cmd_t                    cmd_r;
  logic                    clip_r;
  logic                    colour_nz_r;
  logic signed [POS_W-1:0] x_r, y_r;
  logic [EXT_W-1:0]        w_r, h_r;
  logic [FIELD_W-1:0]      skip_r;
  logic [1:0]              idx_r;
  logic [EXT_W-1:0]        row_r;

  // current span
  logic                      hor_r;
  logic [CNT_W-1:0]          cnt_r, k_r;
  logic signed [COORD_W-1:0] col_r, lrow_r;
  logic [FIELD_W-1:0]        span_skip_r, nskip_r;
  logic signed [ACC_W-1:0]   acc_r;

  logic signed [COORD_W-1:0] x_c, y_c, w_c, h_c, row_c;
  logic                      sp_hor, sp_any;
  logic signed [COORD_W-1:0] sp_x, sp_y, sp_len;
  logic [FIELD_W-1:0]        sp_skip;

  logic signed [COORD_W-1:0] a0, across, lim_al, lim_ac, lim_w, lim_h;
  logic signed [COORD_W-1:0] lo, hi_raw, hi, start_al, col_c, lrow_c;
  logic                      across_ok;
  logic [CNT_W-1:0]          cnt_c;

  logic signed [DIM_W:0]     wcoef;
  logic signed [ACC_W-1:0]   prod, step;
  logic                      drawn, in_range, span_end, last_span;

  assign x_c   = {{(COORD_W-POS_W){x_r[POS_W-1]}}, x_r};
  assign y_c   = {{(COORD_W-POS_W){y_r[POS_W-1]}}, y_r};
  assign w_c   = $signed({{(COORD_W-EXT_W){1'b0}}, w_r});
  assign h_c   = $signed({{(COORD_W-EXT_W){1'b0}}, h_r});
  assign row_c = $signed({{(COORD_W-EXT_W){1'b0}}, row_r});
  assign lim_w = $signed({{(COORD_W-DIM_W){1'b0}}, eff_w});
  assign lim_h = $signed({{(COORD_W-DIM_W){1'b0}}, eff_h});

  // span parameters of the current step of the command
  always_comb begin
    sp_hor  = 1'b1;
    sp_any  = 1'b1;
    sp_x    = x_c;
    sp_y    = y_c;
    sp_len  = ONE_C;
    sp_skip = '0;
    unique case (cmd_r) inside
      CMD_DOT, CMD_DOT_Z, CMD_READ: begin
        sp_len = ONE_C;
      end
      CMD_HSPAN: begin
        sp_len  = w_c;
        sp_skip = clip_r ? '0 : skip_r;
      end
      CMD_VSPAN: begin
        sp_hor = 1'b0;
        sp_len = w_c;
      end
      CMD_OUTLINE: begin
        case (idx_r)
          2'd0: sp_len = w_c;
          2'd1: begin
            sp_y   = y_c + h_c - ONE_C;
            sp_len = w_c;
          end
          2'd2: begin
            sp_hor = 1'b0;
            sp_y   = y_c + ONE_C;
            sp_len = h_c - TWO_C;
          end
          default: begin
            sp_hor = 1'b0;
            sp_x   = x_c + w_c - ONE_C;
            sp_y   = y_c + ONE_C;
            sp_len = h_c - TWO_C;
          end
        endcase
      end
      CMD_FILL: begin
        sp_y   = y_c + row_c;
        sp_len = w_c;
        sp_any = (h_r != '0);
      end
      default: sp_any = 1'b0;
    endcase
  end

  // clip along and across the span
  always_comb begin
    a0        = sp_hor ? sp_x : sp_y;
    across    = sp_hor ? sp_y : sp_x;
    lim_al    = sp_hor ? lim_w : lim_h;
    lim_ac    = sp_hor ? lim_h : lim_w;
    lo        = (a0 < 0) ? '0 : a0;
    hi_raw    = a0 + sp_len;
    hi        = (hi_raw > lim_al) ? lim_al : hi_raw;
    across_ok = (across >= 0) && (across < lim_ac);
    if (clip_r) begin
      cnt_c    = (across_ok && (hi > lo)) ? CNT_W'(hi - lo) : '0;
      start_al = lo;
    end else begin
      cnt_c    = (sp_len > 0) ? CNT_W'(sp_len) : '0;
      start_al = a0;
    end
    col_c  = sp_hor ? start_al : across;
    lrow_c = sp_hor ? across : start_al;
  end

  assign wcoef = $signed({1'b0, eff_w});
  assign prod  = wcoef * lrow_r;
  assign step  = hor_r ? ACC_W'(1) : $signed({{(ACC_W-DIM_W){1'b0}}, eff_w});

  assign span_end = (k_r == cnt_r);
  assign drawn    = (nskip_r == '0);
  assign in_range = (acc_r >= 0) && (acc_r < STORE_A);

  always_comb begin
    unique case (cmd_r) inside
      CMD_OUTLINE: last_span = (idx_r == 2'd3);
      CMD_FILL:    last_span = (row_r == h_r - EXT_W'(1));
      default:     last_span = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (cmd_start) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = sp_any ? ST_ADDR : ST_DRAIN;
      ST_ADDR:  state_nxt = ST_RUN;
      ST_RUN: begin
        if (span_end) state_nxt = last_span ? ST_DRAIN : ST_SETUP;
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_start) begin
          cmd_r       <= cmd;
          clip_r      <= clip;
          colour_nz_r <= colour_nz;
          x_r         <= pos_x;
          y_r         <= pos_y;
          w_r         <= ext_w;
          h_r         <= ext_h;
          skip_r      <= skip;
          idx_r       <= '0;
          row_r       <= '0;
        end
      end
      ST_SETUP: begin
        hor_r       <= sp_hor;
        cnt_r       <= cnt_c;
        col_r       <= col_c;
        lrow_r      <= lrow_c;
        span_skip_r <= sp_skip;
      end
      ST_ADDR: begin
        acc_r   <= prod + ACC_W'(col_r);
        k_r     <= '0;
        nskip_r <= span_skip_r;
      end
      ST_RUN: begin
        if (!span_end) begin
          k_r     <= k_r + CNT_W'(1);
          acc_r   <= acc_r + step;
          nskip_r <= drawn ? span_skip_r : nskip_r - FIELD_W'(1);
        end else if (!last_span) begin
          if (cmd_r == CMD_FILL) row_r <= row_r + EXT_W'(1);
          else                   idx_r <= idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign req.valid  = (state_r == ST_RUN) && !span_end && drawn && in_range &&
                      ((cmd_r == CMD_READ) || colour_nz_r);
  assign req.rd     = (cmd_r == CMD_READ);
  assign req.tested = (cmd_r != CMD_DOT);
  assign req.addr   = acc_r[ADDR_W-1:0];

  assign stat.busy = (state_r != ST_IDLE);
  assign stat.done = (state_r == ST_DONE);

endmodule

### sv/dtsr_rmw.sv
`timescale 1ns / 1ps
// Read-modify-write stage of the frame store, with forwarding, counting and the reset clear.
module dtsr_rmw
  import dtsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_start,
  input  colour_t   new_colour,
  input  depth_t    new_depth,
  input  pix_req_t  req,
  input  word_t     ram_q,
  output ram_port_t ram,
  output logic      clear_busy,
  output result_t   res
);

  pix_req_t           p_r;
  colour_t            colour_r, rd_colour_r;
  depth_t             depth_r, rd_depth_r;
  logic               fwd_valid_r;
  logic [ADDR_W-1:0]  fwd_addr_r;
  word_t              fwd_data_r;
  logic               clear_busy_r;
  logic [ADDR_W-1:0]  clear_idx_r;
  logic [COUNT_W-1:0] count_r;

  word_t old_w, pix_data;
  logic  pix_we;

  // the word written last cycle is not yet visible in the read data
  assign old_w = (fwd_valid_r && (fwd_addr_r == p_r.addr)) ? fwd_data_r : ram_q;

  assign pix_we   = p_r.valid && !p_r.rd && (!p_r.tested || (old_w.depth <= depth_r));
  assign pix_data = p_r.tested ? word_t'{depth: depth_r, colour: colour_r}
                               : word_t'{depth: old_w.depth, colour: colour_r};

  assign ram.raddr = req.addr;
  assign ram.we    = clear_busy_r || pix_we;
  assign ram.waddr = clear_busy_r ? clear_idx_r : p_r.addr;
  assign ram.wdata = clear_busy_r ? '0 : pix_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r          <= '0;
      fwd_valid_r  <= 1'b0;
      clear_busy_r <= 1'b1;
      clear_idx_r  <= '0;
    end else begin
      p_r         <= req;
      fwd_valid_r <= pix_we && !clear_busy_r;
      if (clear_busy_r) begin
        clear_idx_r <= clear_idx_r + ADDR_W'(1);
        if (clear_idx_r == ADDR_W'(STORE_SIZE - 1)) clear_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr_r <= p_r.addr;
    fwd_data_r <= pix_data;
    if (cmd_start) begin
      colour_r    <= new_colour;
      depth_r     <= new_depth;
      rd_colour_r <= '0;
      rd_depth_r  <= '0;
      count_r     <= '0;
    end else begin
      if (p_r.valid && p_r.rd) begin
        rd_colour_r <= old_w.colour;
        rd_depth_r  <= old_w.depth;
      end
      if (pix_we && (count_r != COUNT_CAP)) count_r <= count_r + COUNT_W'(1);
    end
  end

  assign clear_busy = clear_busy_r;
  assign res.colour = rd_colour_r;
  assign res.depth  = rd_depth_r;
  assign res.count  = count_r;

endmodule

### sv/depth_tested_span_rasterizer_unit.sv
`timescale 1ns / 1ps
// Top level of the depth-tested span and rectangle rasterizer.
//
// The block owns a 256 x 256 frame store of colour index and depth, held in one
// single-port-write RAM, and executes one drawing command at a time: dots,
// depth-tested dots, horizontal and vertical spans, rectangle outlines, filled
// rectangles and pixel reads. A command is taken when start is high and busy is
// low; its single result appears on the out_ ports for exactly one cycle with
// out_valid high, and the receiver cannot stall it. After reset the store is
// cleared to zero at one word per cycle, and busy stays high until the clear pass
// ends, so no command is taken before it; configuration writes are taken during
// that pass and at any idle time (cfg_ready is always high). Timing is set by the
// store's single read-modify-write path, one pixel position per cycle: each span
// passes through a clip step, then the width * row + col multiply, then walks its
// pixel positions and closes; each command adds the accept, drain and result
// steps. Unclipped horizontal spans with a skip interval still walk every
// position, skipped ones included.
module depth_tested_span_rasterizer_unit
  import dtsr_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // command request
  input  logic                    start,
  output logic                    busy,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic                    in_clip_mode,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [EXT_W-1:0]        in_extent_w,
  input  logic [EXT_W-1:0]        in_extent_h,
  input  logic [FIELD_W-1:0]      in_colour,
  input  logic [FIELD_W-1:0]      in_depth,
  input  logic [FIELD_W-1:0]      in_skip_interval,
  // result strobe
  output logic                    out_valid,
  output logic [FIELD_W-1:0]      out_read_colour,
  output logic [FIELD_W-1:0]      out_read_depth,
  output logic [COUNT_W-1:0]      out_pixels_written,
  // configuration write
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  logic [CFG_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] eff_w, eff_h;

  logic       accept;
  logic       clear_busy;
  colour_t    new_colour;
  depth_t     new_depth;
  walk_stat_t wstat;
  pix_req_t   req;
  ram_port_t  ram;
  word_t      ram_q;
  result_t    res;

  // Configuration registers. Writes must only be issued while idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_wdata;
        REG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Registers above the store size are capped to it; zero clips everything in clip mode.
  assign eff_w = (32'(width_r)  > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : width_r;
  assign eff_h = (32'(height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_r;

  // Command handshake: busy covers the clear pass and the whole command.
  assign busy   = clear_busy || wstat.busy;
  assign accept = start && !busy;

  // Pixel values are masked to the store's colour and depth widths.
  assign new_colour = colour_t'(in_colour);
  assign new_depth  = depth_t'(in_depth);

  dtsr_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_start (accept),
    .cmd       (cmd_t'(in_cmd)),
    .clip      (in_clip_mode),
    .pos_x     (in_pos_x),
    .pos_y     (in_pos_y),
    .ext_w     (in_extent_w),
    .ext_h     (in_extent_h),
    .colour_nz (new_colour != '0),
    .skip      (in_skip_interval),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .stat      (wstat),
    .req       (req)
  );

  dtsr_rmw u_rmw (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_start  (accept),
    .new_colour (new_colour),
    .new_depth  (new_depth),
    .req        (req),
    .ram_q      (ram_q),
    .ram        (ram),
    .clear_busy (clear_busy),
    .res        (res)
  );

  dtsr_ram #(
    .WIDTH ($bits(word_t)),
    .DEPTH (STORE_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (ram_q)
  );

  // Result strobe: the walker's final state, reached through the drain state after the last write.
  assign out_valid          = wstat.done;
  assign out_read_colour    = FIELD_W'(res.colour);
  assign out_read_depth     = FIELD_W'(res.depth);
  assign out_pixels_written = res.count;

  // Checks on the command sequencing
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after taking a command");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !out_valid && !req.valid)
    else $error("activity during the store clear pass");

  a_no_req_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !wstat.busy |-> !req.valid)
    else $error("pixel request while no command is active");

endmodule
